/* rtl/pih_pkg.sv */
// ----------------------------------------------------------------------------
// pih_pkg: shared types and constants for the point-in-hexahedron test
// Vertex index tables for the cell split and the face triangles.
// ----------------------------------------------------------------------------
package pih_pkg;

  localparam int VOL_BITS = 63;
  localparam logic [62:0] VOL_LIMIT = {63{1'b1}};
  localparam logic [15:0] TOL_RESET = 16'd655;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_TEST = 1'b1;

  localparam logic [0:0] REG_TOLERANCE = 1'b0;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_MUL,
    ST_ACC,
    ST_CMP,
    ST_OUT
  } pih_state_t;

  // Vertex indices of the 17 tetrahedra: first five are cell tets with
  // origin vertex in slot 0; the other twelve use the point as origin.
  // Each entry: {o, a, b, c}, triple product |c . (a x b)| of differences.
  function automatic logic [11:0] tet_verts(input logic [4:0] k);
    logic [11:0] r;
    case (k)
      5'd0:  r = {3'd0, 3'd1, 3'd2, 3'd4};
      5'd1:  r = {3'd1, 3'd4, 3'd5, 3'd7};
      5'd2:  r = {3'd6, 3'd7, 3'd4, 3'd2};
      5'd3:  r = {3'd1, 3'd2, 3'd3, 3'd7};
      5'd4:  r = {3'd4, 3'd7, 3'd1, 3'd2};
      5'd5:  r = {3'd0, 3'd0, 3'd1, 3'd2};
      5'd6:  r = {3'd0, 3'd1, 3'd2, 3'd3};
      5'd7:  r = {3'd0, 3'd4, 3'd5, 3'd6};
      5'd8:  r = {3'd0, 3'd5, 3'd6, 3'd7};
      5'd9:  r = {3'd0, 3'd0, 3'd1, 3'd4};
      5'd10: r = {3'd0, 3'd1, 3'd4, 3'd5};
      5'd11: r = {3'd0, 3'd1, 3'd3, 3'd5};
      5'd12: r = {3'd0, 3'd3, 3'd5, 3'd7};
      5'd13: r = {3'd0, 3'd2, 3'd3, 3'd6};
      5'd14: r = {3'd0, 3'd3, 3'd6, 3'd7};
      5'd15: r = {3'd0, 3'd0, 3'd2, 3'd4};
      5'd16: r = {3'd0, 3'd2, 3'd4, 3'd6};
      default: r = '0;
    endcase
    return r;
  endfunction

  localparam int NUM_TETS = 17;
  localparam int NUM_CELL_TETS = 5;

endpackage

/* rtl/pih_if.sv */
// ----------------------------------------------------------------------------
// pih_if: valid/ready channel interfaces
// Input word carries a load or a test; output word carries one result.
// ----------------------------------------------------------------------------
interface pih_in_if;
  logic        valid;
  logic        ready;
  logic        operation;
  logic [2:0]  vertex_number;
  logic signed [15:0] coord_x;
  logic signed [15:0] coord_y;
  logic signed [15:0] coord_z;
  modport source (output valid, operation, vertex_number, coord_x, coord_y, coord_z,
                  input ready);
  modport sink (input valid, operation, vertex_number, coord_x, coord_y, coord_z,
                output ready);
endinterface

interface pih_out_if;
  logic        valid;
  logic        ready;
  logic        inside_res;
  logic [62:0] cell_volume_six;
  logic [62:0] pyramid_volume_six;
  modport source (output valid, inside_res, cell_volume_six, pyramid_volume_six,
                  input ready);
  modport sink (input valid, inside_res, cell_volume_six, pyramid_volume_six,
                output ready);
endinterface

/* rtl/pih_triple.sv */
// ----------------------------------------------------------------------------
// pih_triple: shared triple-product unit
// |c . (a x b)| in three registered steps: differences, cross, dot.
// ----------------------------------------------------------------------------
module pih_triple
  import pih_pkg::*;
#(
  parameter int CB = 16
) (
  input  logic                 clk,
  input  logic                 start,
  input  logic signed [CB-1:0] o_x, o_y, o_z,
  input  logic signed [CB-1:0] a_x, a_y, a_z,
  input  logic signed [CB-1:0] b_x, b_y, b_z,
  input  logic signed [CB-1:0] c_x, c_y, c_z,
  output logic                 done,
  output logic [62:0]          result
);

  localparam int DW = CB + 1;
  localparam int XW = 2 * DW + 1;
  localparam int PW = XW + DW + 2;

  logic signed [DW-1:0] ax, ay, az, bx, by, bz, cx, cy, cz;
  logic signed [XW-1:0] xx, xy, xz;
  logic signed [DW-1:0] cx2, cy2, cz2;
  logic signed [PW-1:0] dot;
  logic [PW-1:0] mag;
  logic s1, s2;

  // stage 1: differences from the origin vertex
  always_ff @(posedge clk) begin
    s1 <= start;
    ax <= DW'(o_x) - DW'(a_x); ay <= DW'(o_y) - DW'(a_y); az <= DW'(o_z) - DW'(a_z);
    bx <= DW'(o_x) - DW'(b_x); by <= DW'(o_y) - DW'(b_y); bz <= DW'(o_z) - DW'(b_z);
    cx <= DW'(o_x) - DW'(c_x); cy <= DW'(o_y) - DW'(c_y); cz <= DW'(o_z) - DW'(c_z);
  end

  // stage 2: cross product a x b
  always_ff @(posedge clk) begin
    s2  <= s1;
    xx  <= XW'(ay * bz) - XW'(az * by);
    xy  <= XW'(az * bx) - XW'(ax * bz);
    xz  <= XW'(ax * by) - XW'(ay * bx);
    cx2 <= cx; cy2 <= cy; cz2 <= cz;
  end

  // stage 3: dot with c, magnitude
  assign dot = PW'(cx2 * xx) + PW'(cy2 * xy) + PW'(cz2 * xz);
  assign mag = dot[PW-1] ? PW'(-dot) : PW'(dot);

  always_ff @(posedge clk) begin
    done   <= s2;
    result <= 63'(mag);
  end

endmodule

/* rtl/point_in_hexahedron_test.sv */
// A test runs its 17 triple products in turn, each as vertex reads, a start and the
// 3 unit stages, then a compare, before its result word is shown; the single vertex
// memory read port and triple-product unit serve them all. Words are accepted only
// while idle: a new test waits for the last result. Loads accept every cycle when idle.
// Reset: synchronous, active high; clears control and sets tolerance to 655.
// The vertex memory is not cleared: a vertex must be loaded before a test.
// ----------------------------------------------------------------------------
// point_in_hexahedron_test: volume-based point-in-cell test
// Sums 17 triple products through one unit and compares the two volumes.
// ----------------------------------------------------------------------------
module point_in_hexahedron_test
  import pih_pkg::*;
#(
  parameter int COORD_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  pih_in_if.sink      in_ch,
  pih_out_if.source   out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [0:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int CB = COORD_BITS;

  pih_state_t state, state_next;

  logic [15:0] tolerance;
  logic [3*CB-1:0] vmem [8];
  logic [3*CB-1:0] rd_data;
  logic [2:0] rd_addr;
  logic signed [CB-1:0] pt_x, pt_y, pt_z;
  logic signed [CB-1:0] vx [4], vy [4], vz [4];
  logic [4:0] tet;
  logic [1:0] slot;
  logic [1:0] rd_slot;
  logic rd_pend;
  logic tri_start, tri_done;
  logic [62:0] tri_res;
  logic [62:0] cell_vol, pyr;
  logic [63:0] cell_sum, pyr_sum;
  logic [62:0] diff;
  logic [78:0] lhs, rhs;
  logic inside_q;
  logic [11:0] tv;
  logic in_acc;

  assign pready = 1'b1;
  assign prdata = {16'd0, tolerance};

  // tolerance register
  always_ff @(posedge clk) begin
    if (rst) begin
      tolerance <= TOL_RESET;
    end else if (psel && penable && pwrite && paddr == REG_TOLERANCE) begin
      tolerance <= pwdata[15:0];
    end
  end

  assign in_ch.ready = (state == ST_IDLE);
  assign in_acc = in_ch.valid && in_ch.ready;

  // vertex memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (in_acc && in_ch.operation == OP_LOAD) begin
      vmem[in_ch.vertex_number] <= {CB'($unsigned(in_ch.coord_x)),
                                    CB'($unsigned(in_ch.coord_y)),
                                    CB'($unsigned(in_ch.coord_z))};
    end
    rd_data <= vmem[rd_addr];
  end

  assign tv = tet_verts(tet);
  always_comb begin
    case (slot)
      2'd0: rd_addr = tv[11:9];
      2'd1: rd_addr = tv[8:6];
      2'd2: rd_addr = tv[5:3];
      default: rd_addr = tv[2:0];
    endcase
  end

  // sequencer
  always_comb begin
    state_next = state;
    tri_start = 1'b0;
    case (state)
      ST_IDLE: if (in_acc && in_ch.operation == OP_TEST) state_next = ST_READ;
      ST_READ: if (rd_pend && rd_slot == 2'd3) state_next = ST_MUL;
      ST_MUL: begin
        tri_start = 1'b1;
        state_next = ST_ACC;
      end
      ST_ACC: if (tri_done) state_next = (tet == 5'(NUM_TETS - 1)) ? ST_CMP : ST_READ;
      ST_CMP: state_next = ST_OUT;
      ST_OUT: if (out_ch.ready) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      tet <= '0;
      slot <= '0;
      rd_pend <= 1'b0;
    end else begin
      state <= state_next;
      rd_pend <= (state == ST_READ) && !(rd_pend && rd_slot == 2'd3);
      if (state == ST_IDLE) begin
        tet <= '0;
        slot <= '0;
      end else if (state == ST_READ) begin
        if (slot != 2'd3) slot <= slot + 2'd1;
      end else if (state == ST_ACC && tri_done) begin
        tet <= tet + 5'd1;
        slot <= '0;
      end
    end
  end

  // capture read data into vertex slots; for face tets the point replaces slot 0 as origin
  always_ff @(posedge clk) begin
    rd_slot <= slot;
    if (in_acc) begin
      pt_x <= CB'($unsigned(in_ch.coord_x));
      pt_y <= CB'($unsigned(in_ch.coord_y));
      pt_z <= CB'($unsigned(in_ch.coord_z));
    end
    if (state == ST_READ && rd_pend) begin
      vx[rd_slot] <= rd_data[3*CB-1:2*CB];
      vy[rd_slot] <= rd_data[2*CB-1:CB];
      vz[rd_slot] <= rd_data[CB-1:0];
    end
  end

  logic use_pt;
  assign use_pt = (tet >= 5'(NUM_CELL_TETS));

  pih_triple #(.CB(CB)) u_triple (
    .clk(clk), .start(tri_start),
    .o_x(use_pt ? pt_x : vx[0]), .o_y(use_pt ? pt_y : vy[0]),
    .o_z(use_pt ? pt_z : vz[0]),
    .a_x(vx[1]), .a_y(vy[1]), .a_z(vz[1]),
    .b_x(vx[2]), .b_y(vy[2]), .b_z(vz[2]),
    .c_x(vx[3]), .c_y(vy[3]), .c_z(vz[3]),
    .done(tri_done), .result(tri_res)
  );

  // saturating accumulation
  assign cell_sum = {1'b0, cell_vol} + {1'b0, tri_res};
  assign pyr_sum  = {1'b0, pyr} + {1'b0, tri_res};

  always_ff @(posedge clk) begin
    if (state == ST_IDLE) begin
      cell_vol <= '0;
      pyr <= '0;
    end else if (state == ST_ACC && tri_done) begin
      if (!use_pt) cell_vol <= cell_sum[63] ? VOL_LIMIT : cell_sum[62:0];
      else pyr <= pyr_sum[63] ? VOL_LIMIT : pyr_sum[62:0];
    end
  end

  // exact comparison |cell - pyr| * 2^16 < tolerance * cell
  assign diff = (cell_vol > pyr) ? cell_vol - pyr : pyr - cell_vol;
  assign lhs = {diff, 16'd0};
  assign rhs = 79'(cell_vol) * 79'(tolerance);

  always_ff @(posedge clk) begin
    if (state == ST_CMP) inside_q <= (lhs < rhs);
  end

  assign out_ch.valid = (state == ST_OUT);
  assign out_ch.inside_res = inside_q;
  assign out_ch.cell_volume_six = cell_vol;
  assign out_ch.pyramid_volume_six = pyr;

endmodule

/* rtl/pih_checker.sv */
// ----------------------------------------------------------------------------
// pih_checker: port-level checks for the point-in-hexahedron test
// Watches handshakes and result words on the top level.
// ----------------------------------------------------------------------------
module pih_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_inside,
  input logic [62:0] out_cell,
  input logic        pready
);

  // a held result word keeps its cell volume stable
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_cell))
    else $error("result word changed while stalled");

  // no input taken while a result waits
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready)
    else $error("input accepted while result pending");

  // zero cell volume never reports inside
  a_zero_cell: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_cell == '0 |-> !out_inside)
    else $error("inside reported for empty cell");

  a_pready: assert property (@(posedge clk) pready)
    else $error("pready low");

endmodule

bind point_in_hexahedron_test pih_checker u_pih_checker (
  .clk(clk), .rst(rst),
  .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .out_inside(out_ch.inside_res), .out_cell(out_ch.cell_volume_six),
  .pready(pready)
);

/* sim/pih_tb_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pih_tb_if: testbench-side scoreboard package
// Queues expected result words and checks the received ones in order.
// ----------------------------------------------------------------------------
// The block's own interface file (rtl/pih_if.sv) is compiled with the RTL;
// this file only holds the scoreboard class used by the top module.
package pih_tb_pkg;

  // One result word
  typedef struct {
    logic        inside_res;
    logic [62:0] cell_volume_six;
    logic [62:0] pyramid_volume_six;
  } verdict_t;

  class cell_scoreboard;
    verdict_t pending[$];
    int       errors;
    int       matched;

    // note one expected result
    function void note_test(verdict_t v);
      pending = {pending, v};
    endfunction

    // compare one received result against the oldest expectation
    function void check_verdict(verdict_t got);
      verdict_t want;
      if (pending.size() == 0) begin
        $display("%0t unexpected word: inside %0d cell %0d pyr %0d", $time,
                 got.inside_res, got.cell_volume_six, got.pyramid_volume_six);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.inside_res !== want.inside_res) begin
        $display("%0t inside_res: expected %0d actual %0d", $time,
                 want.inside_res, got.inside_res);
        errors++;
      end
      if (got.cell_volume_six !== want.cell_volume_six) begin
        $display("%0t cell_volume_six: expected %0d actual %0d", $time,
                 want.cell_volume_six, got.cell_volume_six);
        errors++;
      end
      if (got.pyramid_volume_six !== want.pyramid_volume_six) begin
        $display("%0t pyramid_volume_six: expected %0d actual %0d", $time,
                 want.pyramid_volume_six, got.pyramid_volume_six);
        errors++;
      end
      matched++;
    endfunction
  endclass

endpackage

/* sim/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: point-in-hexahedron test testbench
// Loads cell vertices, tests points and checks each verdict and both volumes
// against an in-bench volume predictor, over several tolerance settings.
// ----------------------------------------------------------------------------
module tb_top;
  import pih_pkg::*;
  import pih_tb_pkg::*;

  localparam int CB = 16;
  localparam longint CYCLE_LIMIT = 3000000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [0:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  pih_in_if  in_ch ();
  pih_out_if out_ch ();

  point_in_hexahedron_test #(.COORD_BITS(CB)) i_dut (
    .clk(clk), .rst(rst), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state
  logic signed [63:0] corner[8][3];
  logic [15:0] tol_model;
  logic [15:0] tols[5] = '{16'd0, 16'hFFFF, 16'd1, 16'd655, 16'd8000};
  cell_scoreboard sb;
  longint cycles = 0;
  int tests_sent, loads_sent;
  logic stall_on;

  // |c . (a x b)| with differences taken from origin o
  function automatic logic [63:0] abs_triple(logic signed [63:0] o[3],
      logic signed [63:0] p[3], logic signed [63:0] q[3], logic signed [63:0] r[3]);
    logic signed [63:0] a[3], b[3], c[3];
    logic signed [63:0] x, y, z, d;
    for (int i = 0; i < 3; i++) begin
      a[i] = o[i] - p[i];
      b[i] = o[i] - q[i];
      c[i] = o[i] - r[i];
    end
    x = a[1] * b[2] - a[2] * b[1];
    y = a[2] * b[0] - a[0] * b[2];
    z = a[0] * b[1] - a[1] * b[0];
    d = c[0] * x + c[1] * y + c[2] * z;
    return d < 0 ? -d : d;
  endfunction

  function automatic logic [63:0] sat_sum(logic [63:0] a, logic [63:0] b);
    logic [64:0] s;
    s = a + b;
    return (s > 65'h7FFFFFFFFFFFFFFF) ? 64'h7FFFFFFFFFFFFFFF : s[63:0];
  endfunction

  // predict the verdict for point p from the stored corners
  function automatic verdict_t predict_containment(logic signed [63:0] p[3]);
    logic [63:0] cell_vol, pyr, dv;
    logic [127:0] lhs, rhs;
    logic [11:0] tv;
    verdict_t v;
    int face[6][4] = '{'{0,1,2,3}, '{4,5,6,7}, '{0,1,4,5},
                       '{1,3,5,7}, '{2,3,6,7}, '{0,2,4,6}};
    int tet[5][4] = '{'{0,1,2,4}, '{1,4,5,7}, '{6,7,4,2}, '{1,2,3,7}, '{4,7,1,2}};
    cell_vol = 0;
    pyr = 0;
    for (int t = 0; t < 5; t++)
      cell_vol = sat_sum(cell_vol, abs_triple(corner[tet[t][0]], corner[tet[t][1]],
                                              corner[tet[t][2]], corner[tet[t][3]]));
    for (int f = 0; f < 6; f++)
      for (int t = 0; t < 2; t++)
        pyr = sat_sum(pyr, abs_triple(p, corner[face[f][t]], corner[face[f][t+1]],
                                      corner[face[f][t+2]]));
    dv = cell_vol > pyr ? cell_vol - pyr : pyr - cell_vol;
    lhs = {64'd0, dv} << 16;
    rhs = {112'd0, tol_model} * {64'd0, cell_vol};
    v.inside_res = lhs < rhs;
    v.cell_volume_six = cell_vol[62:0];
    v.pyramid_volume_six = pyr[62:0];
    return v;
  endfunction

  // send one word, waiting for acceptance
  task automatic send_word(logic op, logic [2:0] vn, logic [15:0] x, logic [15:0] y,
                           logic [15:0] z);
    logic signed [63:0] p[3];
    in_ch.valid <= 1'b1;
    in_ch.operation <= op;
    in_ch.vertex_number <= vn;
    in_ch.coord_x <= x;
    in_ch.coord_y <= y;
    in_ch.coord_z <= z;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    p[0] = $signed(x);
    p[1] = $signed(y);
    p[2] = $signed(z);
    if (op == OP_LOAD) begin
      corner[vn] = p;
      loads_sent++;
    end else begin
      sb.note_test(predict_containment(p));
      tests_sent++;
    end
  endtask

  task automatic idle_cycles(int n);
    in_ch.valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // APB write: setup then access
  task automatic write_tolerance(logic [15:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= REG_TOLERANCE;
    pwdata <= {16'd0, val};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    tol_model = val;
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (120) @(posedge clk);
  endtask

  function automatic logic [15:0] rnd_coord(int mode);
    case (mode)
      0: return 16'($urandom_range(0, 4095)) - 16'd2048;
      1: return 16'($urandom);
      default: return $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
    endcase
  endfunction

  // a well-formed box with random jitter, or wild corners
  task automatic load_cell(int mode);
    logic [15:0] lo[3], span[3];
    for (int i = 0; i < 3; i++) begin
      lo[i] = 16'($urandom_range(0, 2000)) - 16'd1000;
      span[i] = 16'($urandom_range(16, 1500));
    end
    for (int v = 0; v < 8; v++) begin
      if (mode == 0)
        send_word(OP_LOAD, 3'(v),
                  lo[0] + (v[0] ? span[0] : 16'd0) + 16'($urandom_range(0, 7)),
                  lo[1] + (v[1] ? span[1] : 16'd0) + 16'($urandom_range(0, 7)),
                  lo[2] + (v[2] ? span[2] : 16'd0) + 16'($urandom_range(0, 7)));
      else
        send_word(OP_LOAD, 3'(v), rnd_coord(mode), rnd_coord(mode), rnd_coord(mode));
      if ($urandom_range(0, 3) == 0) idle_cycles($urandom_range(1, 6));
    end
  endtask

  task automatic random_phase(int n);
    logic [15:0] c[3];
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(0, 9) == 0) begin
        load_cell($urandom_range(0, 5) == 0 ? $urandom_range(1, 2) : 0);
      end else if ($urandom_range(0, 19) == 0) begin
        send_word(OP_LOAD, 3'($urandom), rnd_coord(0), rnd_coord(0), rnd_coord(0));
      end else begin
        // mostly near the cell, sometimes anywhere
        for (int i = 0; i < 3; i++)
          c[i] = ($urandom_range(0, 4) == 0) ? rnd_coord(1)
               : corner[$urandom_range(0, 7)][i][15:0] + 16'($urandom_range(0, 800))
                 - 16'd400;
        send_word(OP_TEST, 3'($urandom), c[0], c[1], c[2]);
      end
      // bursts with random gaps
      if ($urandom_range(0, 5) == 0) idle_cycles($urandom_range(1, 40));
    end
  endtask

  // receiver stall pattern: long runs of ready and of stall
  always @(posedge clk) begin
    if (rst) begin
      stall_on <= 1'b0;
      out_ch.ready <= 1'b0;
    end else begin
      if ($urandom_range(0, 15) == 0) stall_on <= ~stall_on;
      out_ch.ready <= stall_on ? ($urandom_range(0, 3) == 0) : 1'b1;
    end
  end

  // result monitor
  always @(posedge clk) begin
    verdict_t got;
    if (!rst && out_ch.valid && out_ch.ready) begin
      got.inside_res = out_ch.inside_res;
      got.cell_volume_six = out_ch.cell_volume_six;
      got.pyramid_volume_six = out_ch.pyramid_volume_six;
      sb.check_verdict(got);
    end
  end

  // run-length guard
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("FAILED: results differ");
      $finish;
    end
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.operation = OP_LOAD;
    in_ch.vertex_number = '0;
    in_ch.coord_x = '0;
    in_ch.coord_y = '0;
    in_ch.coord_z = '0;
    sb = new();
    tol_model = TOL_RESET;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: unit cube scaled, centre, corner, far point, extremes
    for (int v = 0; v < 8; v++)
      send_word(OP_LOAD, 3'(v), v[0] ? 16'd160 : 16'd0, v[1] ? 16'd160 : 16'd0,
                v[2] ? 16'd160 : 16'd0);
    send_word(OP_TEST, 3'd0, 16'd80, 16'd80, 16'd80);
    send_word(OP_TEST, 3'd7, 16'd0, 16'd0, 16'd0);
    send_word(OP_TEST, 3'd5, 16'd400, 16'd80, 16'd80);
    send_word(OP_TEST, 3'd0, 16'h7FFF, 16'h8000, 16'h7FFF);
    send_word(OP_TEST, 3'd0, 16'hFFFF, 16'h0001, 16'h8000);
    // degenerate cell: all corners equal, zero volume
    for (int v = 0; v < 8; v++) send_word(OP_LOAD, 3'(v), 16'd5, 16'd5, 16'd5);
    send_word(OP_TEST, 3'd0, 16'd5, 16'd5, 16'd5);
    // extreme corners push the sums hard
    for (int v = 0; v < 8; v++)
      send_word(OP_LOAD, 3'(v), v[0] ? 16'h7FFF : 16'h8000, v[1] ? 16'h7FFF : 16'h8000,
                v[2] ? 16'h7FFF : 16'h8000);
    send_word(OP_TEST, 3'd0, 16'h8000, 16'h7FFF, 16'h0000);
    drain();

    // random phases over several tolerance settings
    foreach (tols[i]) begin
      write_tolerance(tols[i]);
      load_cell(0);
      random_phase(75);
      drain();
    end

    $display("covered %0d loads and %0d point tests over 5 tolerance settings",
             loads_sent, tests_sent);
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

endmodule

/* point_in_hexahedron_test.f */
rtl/pih_pkg.sv
rtl/pih_if.sv
rtl/pih_triple.sv
rtl/point_in_hexahedron_test.sv
rtl/pih_checker.sv
sim/pih_tb_if.sv
sim/tb_top.sv
